### rtl/bdeque_pkg.sv
// Shared types and codes for the bounded deque with positional delete.
package bdeque_pkg;

  // Request action codes carried in the lowest bits of the input tdata.
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DELETE_AT  = 3'd4;
  localparam logic [2:0] ACT_CLEAR      = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // Fixed field widths of the stream payloads.
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 104;

  // Cell index width; covers the largest supported chain of 256 cells.
  localparam int unsigned IDX_W = 8;

  // What every cell of the chain does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_REMOVE
  } cell_op_e;

  // Command broadcast from the controller to all cells.
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] at;       // target cell of a push back or a removal
    logic [IDX_W-1:0] rem_at;   // cell whose word is tapped as the removed word
    logic [IDX_W-1:0] back_at;  // cell whose word is tapped as the back word
  } chain_cmd_t;

endpackage

### rtl/bdeque_cell.sv
// One storage cell of the deque chain with its neighbor shift and read taps.
module bdeque_cell
  import bdeque_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  chain_cmd_t            cmd_i,
  input  logic [DATA_WIDTH-1:0] load_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rem_tap_o,
  output logic [DATA_WIDTH-1:0] back_tap_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  // Pick the new word: own hold, the new word, or a neighbor's word.
  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_PUSH_FRONT: begin
        data_d = (MyIdx == '0) ? load_i : prev_i;
      end
      CELL_PUSH_BACK: begin
        if (MyIdx == cmd_i.at) data_d = load_i;
      end
      CELL_REMOVE: begin
        if (MyIdx >= cmd_i.at) data_d = next_i;
      end
      default: data_d = data_q;
    endcase
  end

  // The stored word needs no reset; it is only read once written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign rem_tap_o  = (MyIdx == cmd_i.rem_at)  ? data_q : '0;
  assign back_tap_o = (MyIdx == cmd_i.back_at) ? data_q : '0;

endmodule

### rtl/bounded_deque_with_positional_delete.sv
// Top level of the bounded deque: request decode, cell chain and result register.
//
// Usage: requests enter on the s_axis channel; each one pushes a word at the
// front or back, pops the front or back, deletes the entry at a position
// counted from the front, or clears the queue. Every request yields exactly
// one result on the m_axis channel with the removed word, a status, the new
// count and the words now at the front and back.
// A request accepted at one edge updates the cell chain at that edge; its
// result is loaded into the output register at the next edge at which that
// register is free, and m_axis_tvalid rises with that load.
// Throughput: one request per cycle while the receiver keeps m_axis_tready
// high. Each cell takes its new word from itself, the request, or one of its
// two neighbors, so every action updates the whole chain at once.
// Stall: one finished request can wait between the chain and the output
// register; with that stage and the output register both occupied,
// s_axis_tready drops until the receiver takes the pending result.
// Reset: the queue is empty and no result is pending; cell contents are
// not cleared, since only cells below the count are ever read.
module bounded_deque_with_positional_delete
  import bdeque_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: action[2:0], push_value[34:3], position[38:35], zero pad.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: removed_value[31:0], status[33:32], entry_count[38:34],
  // front_value[70:39], back_value[102:71], zero pad.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;

  // Request fields.
  logic [ACTION_W-1:0]   action;
  logic [WORD_W-1:0]     push_value;
  logic [POS_W-1:0]      position;
  logic [DATA_WIDTH-1:0] load_word;

  assign action     = s_axis_tdata[ACTION_W-1:0];
  assign push_value = s_axis_tdata[ACTION_W+WORD_W-1:ACTION_W];
  assign position   = s_axis_tdata[ACTION_W+WORD_W+POS_W-1:ACTION_W+WORD_W];
  assign load_word  = DATA_WIDTH'(push_value);

  // Control and result registers.
  logic [CW-1:0]       count_q, count_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   rem_q;
  logic [STATUS_W-1:0] status_q;
  logic [WORD_W-1:0]   out_rem_q, out_front_q, out_back_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic accept;
  logic out_free;
  logic load_out;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign load_out      = pend_q && out_free;
  assign s_axis_tready = !pend_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Chain wiring.
  chain_cmd_t            cmd;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] rem_tap   [DEPTH];
  logic [DATA_WIDTH-1:0] back_tap  [DEPTH];
  logic [DATA_WIDTH-1:0] rem_word;
  logic [DATA_WIDTH-1:0] back_word;

  // Request decode into a chain command, a status and the new count.
  logic                full, empty, removing;
  logic [STATUS_W-1:0] status_d;

  always_comb begin
    full        = (count_q >= CW'(DEPTH));
    empty       = (count_q == '0);
    removing    = 1'b0;
    status_d    = ST_OK;
    count_d     = count_q;
    cmd.op      = CELL_HOLD;
    cmd.at      = '0;
    cmd.rem_at  = '0;
    cmd.back_at = IDX_W'(count_q - CW'(1));
    unique case (action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.op  = CELL_PUSH_FRONT;
          count_d = count_q + CW'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.op  = CELL_PUSH_BACK;
          cmd.at  = IDX_W'(count_q);
          count_d = count_q + CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          removing = 1'b1;
          cmd.op   = CELL_REMOVE;
          count_d  = count_q - CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          removing = 1'b1;
          cmd.op   = CELL_REMOVE;
          cmd.at   = IDX_W'(count_q - CW'(1));
          count_d  = count_q - CW'(1);
        end
      end
      ACT_DELETE_AT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (CMP_W'(position) >= CMP_W'(count_q)) begin
          status_d = ST_BADPOS;
        end else begin
          removing = 1'b1;
          cmd.op   = CELL_REMOVE;
          cmd.at   = IDX_W'(position);
          count_d  = count_q - CW'(1);
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    cmd.rem_at = cmd.at;
    // Nothing moves in the chain unless a request is taken this cycle.
    if (!accept) cmd.op = CELL_HOLD;
  end

  // The chain of cells, front at cell 0.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = cell_data[g];
    end else begin : g_mid_prev
      assign prev_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cell_data[g];
    end else begin : g_mid_next
      assign next_w = cell_data[g+1];
    end
    bdeque_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .load_i     (load_word),
      .prev_i     (prev_w),
      .next_i     (next_w),
      .data_o     (cell_data[g]),
      .rem_tap_o  (rem_tap[g]),
      .back_tap_o (back_tap[g])
    );
  end

  // Gather the one-hot taps of the chain.
  always_comb begin
    rem_word  = '0;
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rem_word  = rem_word | rem_tap[i];
      back_word = back_word | back_tap[i];
    end
  end

  // Handshake and count registers.
  always_comb begin
    pend_d = pend_q;
    if (accept) pend_d = 1'b1;
    else if (out_free) pend_d = 1'b0;
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) count_q <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Removed word and status of the request waiting for the output register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q    <= removing ? WORD_W'(rem_word) : '0;
      status_q <= status_d;
    end
  end

  // Output register; the chain and count already show this request's result.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rem_q    <= rem_q;
      out_status_q <= status_q;
      out_count_q  <= COUNT_W'(count_q);
      out_front_q  <= (count_q != '0) ? WORD_W'(cell_data[0]) : '0;
      out_back_q   <= (count_q != '0) ? WORD_W'(back_word) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_back_q, out_front_q, out_count_q, out_status_q, out_rem_q};

endmodule

### rtl/bdeque_checker.sv
// Port-level checks of the bounded deque and their binding to the top level.
module bdeque_checker
  import bdeque_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [WORD_W-1:0]   rem_f, front_f, back_f;
  logic [STATUS_W-1:0] status_f;
  logic [COUNT_W-1:0]  count_f;

  assign rem_f    = m_axis_tdata[31:0];
  assign status_f = m_axis_tdata[33:32];
  assign count_f  = m_axis_tdata[38:34];
  assign front_f  = m_axis_tdata[70:39];
  assign back_f   = m_axis_tdata[102:71];

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The reported count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(count_f) <= DEPTH || DEPTH > 31)
    else $error("entry count above capacity");

  // An empty queue reports zero front and back words.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && count_f == '0 && DEPTH < 32 |-> front_f == '0 && back_f == '0)
    else $error("empty queue shows front or back word");

  // A failed request removes nothing.
  a_fail_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status_f != ST_OK |-> rem_f == '0)
    else $error("failed request returned a word");

  // A queue with a single entry shows the same word at both ends.
  a_single_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && count_f == COUNT_W'(1) |-> front_f == back_f)
    else $error("single entry shows different front and back");

endmodule

bind bounded_deque_with_positional_delete bdeque_checker #(.DEPTH(DEPTH)) u_bdeque_checker (.*);

### test/tb.sv
// Self-checking testbench for the bounded deque with positional delete.
module tb;
  import bdeque_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned SEGMENTS_PER_PHASE = 6;
  localparam int unsigned ITEMS_PER_SEGMENT = 38;

  // Action codes the block treats as no operation.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  // One result transaction, laid out as on m_axis_tdata from bit 0 up.
  typedef struct packed {
    logic [WORD_W-1:0]   back_value;
    logic [WORD_W-1:0]   front_value;
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   removed_value;
  } deque_result_t;

  // Tracks the queue contents and the results still owed by the block.
  class deque_scoreboard;
    logic [WORD_W-1:0] words[$];
    deque_result_t owed_results[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Apply one accepted request to the shadow queue and record its result.
    function void note_request(logic [2:0] act, logic [WORD_W-1:0] val, logic [POS_W-1:0] pos);
      deque_result_t res;
      res = '0;
      res.status = ST_OK;
      case (act)
        ACT_PUSH_FRONT: begin
          if (words.size() >= QDEPTH) res.status = ST_FULL;
          else words.push_front(val);
        end
        ACT_PUSH_BACK: begin
          if (words.size() >= QDEPTH) res.status = ST_FULL;
          else words.push_back(val);
        end
        ACT_POP_FRONT: begin
          if (words.size() == 0) res.status = ST_EMPTY;
          else res.removed_value = words.pop_front();
        end
        ACT_POP_BACK: begin
          if (words.size() == 0) res.status = ST_EMPTY;
          else res.removed_value = words.pop_back();
        end
        ACT_DELETE_AT: begin
          if (words.size() == 0) begin
            res.status = ST_EMPTY;
          end else if (pos >= words.size()) begin
            res.status = ST_BADPOS;
          end else begin
            res.removed_value = words[pos];
            words.delete(pos);
          end
        end
        ACT_CLEAR: begin
          words.delete();
        end
        default: begin
        end
      endcase
      res.entry_count = COUNT_W'(words.size());
      if (words.size() != 0) begin
        res.front_value = words[0];
        res.back_value  = words[words.size()-1];
      end
      owed_results.push_back(res);
    endfunction

    // Compare one result transaction with the oldest owed result.
    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      deque_result_t got;
      deque_result_t exp;
      got = deque_result_t'(tdata[$bits(deque_result_t)-1:0]);
      if (owed_results.size() == 0) begin
        $error("Result transaction with no request outstanding: %h", tdata);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.removed_value !== exp.removed_value) begin
        $error("removed_value expected %h actual %h", exp.removed_value, got.removed_value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status expected %0d actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count expected %0d actual %0d", exp.entry_count, got.entry_count);
        errors++;
      end
      if (got.front_value !== exp.front_value) begin
        $error("front_value expected %h actual %h", exp.front_value, got.front_value);
        errors++;
      end
      if (got.back_value !== exp.back_value) begin
        $error("back_value expected %h actual %h", exp.back_value, got.back_value);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  deque_scoreboard board = new();

  bounded_deque_with_positional_delete #(
    .DEPTH      (QDEPTH),
    .DATA_WIDTH (WORD_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check every result transaction as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Issue one request transaction; entered and left at a falling edge.
  task automatic send_request(input logic [2:0] act, input logic [WORD_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pos, val, act};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(act, val, pos);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly extreme or random words.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // One random request; push_pct sets how strongly the queue drifts toward full.
  task automatic random_request(input int unsigned push_pct);
    int unsigned roll;
    int unsigned held;
    logic [2:0] act;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(99);
    held = board.words.size();
    pos  = POS_W'($urandom_range(QDEPTH-1));
    if (roll < 3) begin
      act = ACT_CLEAR;
    end else if (roll < 5) begin
      act = $urandom_range(1) ? ACT_SPARE_7 : ACT_SPARE_6;
    end else if (roll < 5 + push_pct) begin
      act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    end else begin
      case ($urandom_range(2))
        0: act = ACT_POP_FRONT;
        1: act = ACT_POP_BACK;
        default: begin
          act = ACT_DELETE_AT;
          // Mostly valid positions, with some past the end.
          if (held != 0 && $urandom_range(99) < 80) pos = POS_W'($urandom_range(held-1));
        end
      endcase
    end
    send_request(act, pick_word(), pos);
  endtask

  // Run a fixed time limit in parallel with the test.
  initial begin
    #6000000;
    $display("FAIL bounded_deque_with_positional_delete");
    $finish;
  end

  initial begin
    int unsigned push_pct;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: the empty cases, a fill to full, full and position errors.
    send_request(ACT_POP_FRONT, '1, '1);
    send_request(ACT_POP_BACK, '1, '1);
    send_request(ACT_DELETE_AT, '0, '0);
    send_request(ACT_SPARE_6, '1, '1);
    for (int i = 0; i < QDEPTH; i++) begin
      send_request((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                   (i == 0) ? '0 : (i == 1) ? '1 : $urandom(), i[POS_W-1:0]);
    end
    send_request(ACT_PUSH_FRONT, 32'h5a5a_a5a5, '0);
    send_request(ACT_PUSH_BACK, 32'ha5a5_5a5a, '0);
    send_request(ACT_DELETE_AT, '0, 4'd15);
    send_request(ACT_DELETE_AT, '1, 4'd15);
    send_request(ACT_DELETE_AT, '0, 4'd0);
    send_request(ACT_SPARE_7, '0, '0);
    send_request(ACT_CLEAR, '1, '1);
    send_request(ACT_POP_BACK, '0, '0);

    // Random part: four idling phases, each in segments with a drifting fill bias.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
        case ($urandom_range(2))
          0: push_pct = 70;
          1: push_pct = 45;
          default: push_pct = 25;
        endcase
        for (int n = 0; n < ITEMS_PER_SEGMENT; n++) random_request(push_pct);
      end
      wait_for_drain();
    end

    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASS bounded_deque_with_positional_delete");
    end else begin
      $display("FAIL bounded_deque_with_positional_delete");
    end
    $finish;
  end

endmodule
